FILE: hdl/garch_pkg.sv
`default_nettype none

package garch_pkg;

  // Word format: signed fixed point with FracBits fraction bits.
  localparam int DataW    = 32;
  localparam int FracBits = 16;

  // Largest supported orders, and the width of an order register.
  localparam int MaxArchOrder  = 2;
  localparam int MaxGarchOrder = 2;
  localparam int OrderW        = 2;

  // Exact product, rounded term and accumulated sum widths.
  localparam int ProdW = 2 * DataW;
  localparam int TermW = ProdW - FracBits;
  localparam int SumW  = TermW + 3;

  // Configuration register index.
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegOmega        = 3'd0,
    RegArchOrder    = 3'd1,
    RegGarchOrder   = 3'd2,
    RegArchCoefOne  = 3'd3,
    RegArchCoefTwo  = 3'd4,
    RegGarchCoefOne = 3'd5,
    RegGarchCoefTwo = 3'd6
  } garch_reg_e;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic [DataW-1:0]  omega;
    logic [OrderW-1:0] arch_order;
    logic [OrderW-1:0] garch_order;
    logic [DataW-1:0]  arch_coef_one;
    logic [DataW-1:0]  arch_coef_two;
    logic [DataW-1:0]  garch_coef_one;
    logic [DataW-1:0]  garch_coef_two;
  } garch_cfg_t;

  // One result of the recursion.
  typedef struct packed {
    logic [DataW-1:0] variance;
    logic             warm_up;
    logic             saturated;
  } garch_res_t;

  // Orders above the supported maximum are used as the maximum.
  function automatic logic [OrderW-1:0] eff_order(logic [OrderW-1:0] ord,
                                                  logic [OrderW-1:0] lim);
    return (ord > lim) ? lim : ord;
  endfunction

  // Exact signed product, rounded to FracBits fraction bits (halves go up).
  function automatic logic signed [TermW-1:0] fx_term(logic [DataW-1:0] coef,
                                                      logic [DataW-1:0] x);
    logic signed [ProdW-1:0] prod;
    logic signed [ProdW-1:0] half;
    logic signed [ProdW-1:0] rnd;
    prod = ProdW'($signed(coef)) * ProdW'($signed(x));
    half = $signed(ProdW'(1) << (FracBits - 1));
    rnd  = prod + half;
    return TermW'(rnd >>> FracBits);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/garch_cfg.sv
`default_nettype none

module garch_cfg
  import garch_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_en_i,
  input  wire logic [CfgIdxW-1:0] wr_index_i,
  input  wire logic [DataW-1:0]   wr_data_i,
  output garch_cfg_t              cfg_o
);

  // Value after reset: everything zero except the two orders.
  localparam garch_cfg_t CfgReset = '{
    arch_order:  OrderW'(1),
    garch_order: OrderW'(1),
    default:     '0
  };

  garch_cfg_t cfg_q, cfg_d;

  // Decode a register write; unknown indexes leave everything unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (garch_reg_e'(wr_index_i))
        RegOmega:        cfg_d.omega          = wr_data_i;
        RegArchOrder:    cfg_d.arch_order     = wr_data_i[OrderW-1:0];
        RegGarchOrder:   cfg_d.garch_order    = wr_data_i[OrderW-1:0];
        RegArchCoefOne:  cfg_d.arch_coef_one  = wr_data_i;
        RegArchCoefTwo:  cfg_d.arch_coef_two  = wr_data_i;
        RegGarchCoefOne: cfg_d.garch_coef_one = wr_data_i;
        RegGarchCoefTwo: cfg_d.garch_coef_two = wr_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // Register file, both orders start at one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/garch_core.sv
`default_nettype none

module garch_core
  import garch_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire garch_cfg_t       cfg_i,
  input  wire logic             step_i,
  input  wire logic [DataW-1:0] sq_residual_i,
  input  wire logic [DataW-1:0] init_variance_i,
  input  wire logic             series_start_i,
  output garch_res_t            res_o
);

  localparam logic [OrderW-1:0] ArchLim  = OrderW'(MaxArchOrder);
  localparam logic [OrderW-1:0] GarchLim = OrderW'(MaxGarchOrder);
  localparam logic [DataW-1:0]  PosMax   = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0]  NegMax   = {1'b1, {(DataW-1){1'b0}}};

  // History of squared residuals and emitted variances, index zero most recent.
  logic [DataW-1:0]  res_hist0_q, res_hist1_q;
  logic [DataW-1:0]  var_hist0_q, var_hist1_q;
  logic [OrderW-1:0] pos_q, pos_d;

  logic [OrderW-1:0] p_ord, q_ord, r_ord, pos_eff;
  logic              warm;

  logic signed [TermW-1:0] term_a1, term_a2, term_g1, term_g2;
  logic signed [SumW-1:0]  sum;
  logic                    sum_ovf;
  logic [DataW-1:0]        sum_sat;
  logic [DataW-1:0]        h;

  // Effective orders and the warm-up decision.
  always_comb begin
    p_ord   = eff_order(cfg_i.arch_order, ArchLim);
    q_ord   = eff_order(cfg_i.garch_order, GarchLim);
    r_ord   = (p_ord > q_ord) ? p_ord : q_ord;
    pos_eff = series_start_i ? '0 : pos_q;
    warm    = (pos_eff < r_ord);
    pos_d   = warm ? pos_eff + OrderW'(1) : pos_eff;
  end

  // Four rounded products in parallel; unused taps contribute nothing.
  always_comb begin
    term_a1 = (p_ord >= OrderW'(1)) ? fx_term(cfg_i.arch_coef_one, res_hist0_q) : '0;
    term_a2 = (p_ord >= OrderW'(2)) ? fx_term(cfg_i.arch_coef_two, res_hist1_q) : '0;
    term_g1 = (q_ord >= OrderW'(1)) ? fx_term(cfg_i.garch_coef_one, var_hist0_q) : '0;
    term_g2 = (q_ord >= OrderW'(2)) ? fx_term(cfg_i.garch_coef_two, var_hist1_q) : '0;
  end

  // Exact sum, then clip to the word range when the upper bits disagree.
  always_comb begin
    sum = SumW'($signed(cfg_i.omega)) + SumW'(term_a1) + SumW'(term_a2)
        + SumW'(term_g1) + SumW'(term_g2);
    sum_ovf = !((&sum[SumW-1:DataW-1]) || !(|sum[SumW-1:DataW-1]));
    if (sum_ovf) begin
      sum_sat = sum[SumW-1] ? NegMax : PosMax;
    end else begin
      sum_sat = sum[DataW-1:0];
    end
  end

  // Warm-up gives zero first and the initial variance in the last q slots.
  always_comb begin
    if (warm) begin
      h = (pos_eff >= (r_ord - q_ord)) ? init_variance_i : '0;
    end else begin
      h = sum_sat;
    end
    res_o.variance  = h;
    res_o.warm_up   = warm;
    res_o.saturated = !warm && sum_ovf;
  end

  // History advances once for every item processed; the position advances only during warm-up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_hist0_q <= '0;
      res_hist1_q <= '0;
      var_hist0_q <= '0;
      var_hist1_q <= '0;
      pos_q       <= '0;
    end else if (step_i) begin
      res_hist1_q <= res_hist0_q;
      res_hist0_q <= sq_residual_i;
      var_hist1_q <= var_hist0_q;
      var_hist0_q <= h;
      pos_q       <= pos_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/garch_variance_recursion_unit.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   sq_residual_i, init_variance_i,
//                                                series_start_i
// out       output     out_valid_o / out_stall_i variance_o, warm_up_o, saturated_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One request is accepted every cycle unless stalled, via the input and result registers.
// The variance feedback closes through four multipliers and one adder.
// Reset clears the valid flags, the histories and the series position.
// A stalled result holds in the output register while one more request waits
// in the input register; further requests are stalled until the output drains.
// Configuration writes are always ready and take effect on the next cycle.
`default_nettype none

module garch_variance_recursion_unit
  import garch_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [DataW-1:0]   sq_residual_i,
  input  wire logic [DataW-1:0]   init_variance_i,
  input  wire logic               series_start_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [DataW-1:0]        variance_o,
  output logic                    warm_up_o,
  output logic                    saturated_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [DataW-1:0]   cfg_data_i
);

  garch_cfg_t cfg;
  garch_res_t res;
  garch_res_t res_q;

  logic             in_valid_q;
  logic [DataW-1:0] sq_residual_q, init_variance_q;
  logic             series_start_q;
  logic             out_valid_q;
  logic             in_take, advance, out_take;

  // Configuration register file.
  assign cfg_ready_o = 1'b1;

  garch_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: the held request moves on whenever the output register is free or being read.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sq_residual_q   <= sq_residual_i;
      init_variance_q <= init_variance_i;
      series_start_q  <= series_start_i;
    end
  end

  // Recursion datapath with its history.
  garch_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .step_i          (advance),
    .sq_residual_i   (sq_residual_q),
    .init_variance_i (init_variance_q),
    .series_start_i  (series_start_q),
    .res_o           (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign variance_o  = res_q.variance;
  assign warm_up_o   = res_q.warm_up;
  assign saturated_o = res_q.saturated;

  // A warm-up value is never reported as clipped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && warm_up_o |-> !saturated_o)
    else $error("warm-up result flagged as saturated");

  // A clipped result sits at one end of the word range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      variance_o == {1'b0, {(DataW-1){1'b1}}} || variance_o == {1'b1, {(DataW-1){1'b0}}})
    else $error("saturated result not at a range limit");

  // Input is stalled only while a request waits behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

  // A processed request always lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed request lost");

endmodule

`default_nettype wire

FILE: tb/garch_variance_recursion_unit_checker.sv
`timescale 1ns / 100ps

module garch_variance_recursion_unit_checker
  import garch_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic [DataW-1:0]   sq_residual_i,
  input  wire logic [DataW-1:0]   init_variance_i,
  input  wire logic               series_start_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic [DataW-1:0]   variance_i,
  input  wire logic               warm_up_i,
  input  wire logic               saturated_i,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [DataW-1:0]   cfg_data_i,
  output int                      pending_o,
  output int                      fail_count_o
);

  // Bounds of a signed 32-bit word, held in 64 bits for the sum.
  localparam longint SumHigh = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SumLow  = 64'shFFFF_FFFF_8000_0000;

  // Shadow copy of the register file and of the recursion state.
  garch_cfg_t       regs;
  logic [DataW-1:0] residual_hist [2];
  logic [DataW-1:0] variance_hist [2];
  int               series_pos;

  // Predicted variances, oldest first.
  garch_res_t       variance_q [$];

  // An order register above the supported maximum counts as the maximum.
  function automatic int clamp_order(logic [OrderW-1:0] ord, int limit);
    return (int'(ord) > limit) ? limit : int'(ord);
  endfunction

  // Exact product of two Q16.16 words, rounded to Q16.16 with halves going up.
  function automatic longint rounded_product(logic [DataW-1:0] coef,
                                             logic [DataW-1:0] x);
    longint prod;
    prod = longint'($signed(coef)) * longint'($signed(x));
    return (prod + (longint'(1) << (FracBits - 1))) >>> FracBits;
  endfunction

  // Advances the series by one period and gives the variance it produces.
  task automatic advance_series(input logic [DataW-1:0] e2,
                                input logic [DataW-1:0] h0,
                                input logic             start,
                                output garch_res_t      res);
    int     p;
    int     q;
    int     r;
    longint acc;
    p   = clamp_order(regs.arch_order, MaxArchOrder);
    q   = clamp_order(regs.garch_order, MaxGarchOrder);
    r   = (p > q) ? p : q;
    res = '0;
    if (start) begin
      series_pos = 0;
    end
    if (series_pos < r) begin
      // Warm-up: zeros first, the initial variance in the last q slots.
      res.warm_up  = 1'b1;
      res.variance = (series_pos >= r - q) ? h0 : '0;
      series_pos++;
    end else begin
      acc = longint'($signed(regs.omega));
      if (p >= 1) acc += rounded_product(regs.arch_coef_one, residual_hist[0]);
      if (p >= 2) acc += rounded_product(regs.arch_coef_two, residual_hist[1]);
      if (q >= 1) acc += rounded_product(regs.garch_coef_one, variance_hist[0]);
      if (q >= 2) acc += rounded_product(regs.garch_coef_two, variance_hist[1]);
      if (acc > SumHigh) begin
        acc           = SumHigh;
        res.saturated = 1'b1;
      end else if (acc < SumLow) begin
        acc           = SumLow;
        res.saturated = 1'b1;
      end
      res.variance = DataW'(acc);
    end
    residual_hist[1] = residual_hist[0];
    residual_hist[0] = e2;
    variance_hist[1] = variance_hist[0];
    variance_hist[0] = res.variance;
  endtask

  // Watches all three channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    garch_res_t oldest;
    garch_res_t predicted;
    if (!rst_ni) begin
      regs             = '0;
      regs.arch_order  = 2'd1;
      regs.garch_order = 2'd1;
      residual_hist    = '{default: '0};
      variance_hist    = '{default: '0};
      series_pos       = 0;
      variance_q.delete();
      pending_o        = 0;
      fail_count_o     = 0;
    end else begin
      // A delivered result is compared with the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        if (variance_q.size() == 0) begin
          $error("unexpected result: variance %h warm_up %b saturated %b",
                 variance_i, warm_up_i, saturated_i);
          fail_count_o++;
        end else begin
          oldest = variance_q.pop_front();
          if (variance_i !== oldest.variance) begin
            $error("variance: expected %h, actual %h", oldest.variance, variance_i);
            fail_count_o++;
          end
          if (warm_up_i !== oldest.warm_up) begin
            $error("warm_up: expected %b, actual %b", oldest.warm_up, warm_up_i);
            fail_count_o++;
          end
          if (saturated_i !== oldest.saturated) begin
            $error("saturated: expected %b, actual %b", oldest.saturated, saturated_i);
            fail_count_o++;
          end
        end
      end

      // Register writes; an unknown index leaves everything as it was.
      if (cfg_valid_i && cfg_ready_i) begin
        case (garch_reg_e'(cfg_index_i))
          RegOmega:        regs.omega          = cfg_data_i;
          RegArchOrder:    regs.arch_order     = cfg_data_i[OrderW-1:0];
          RegGarchOrder:   regs.garch_order    = cfg_data_i[OrderW-1:0];
          RegArchCoefOne:  regs.arch_coef_one  = cfg_data_i;
          RegArchCoefTwo:  regs.arch_coef_two  = cfg_data_i;
          RegGarchCoefOne: regs.garch_coef_one = cfg_data_i;
          RegGarchCoefTwo: regs.garch_coef_two = cfg_data_i;
          default: ;
        endcase
      end

      // Every accepted request yields exactly one variance.
      if (in_valid_i && !in_stall_i) begin
        advance_series(sq_residual_i, init_variance_i, series_start_i, predicted);
        variance_q.push_back(predicted);
      end

      pending_o = variance_q.size();
    end
  end

endmodule

FILE: tb/garch_variance_recursion_unit_test.sv
`timescale 1ns / 100ps

module garch_variance_recursion_unit_test;
  import garch_pkg::*;

  // Index outside the register map, written to check that it is ignored.
  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic [DataW-1:0]   sq_residual_i   = '0;
  logic [DataW-1:0]   init_variance_i = '0;
  logic               series_start_i  = 1'b0;
  logic               out_stall_i     = 1'b0;
  logic               cfg_valid_i     = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i     = '0;
  logic [DataW-1:0]   cfg_data_i      = '0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic [DataW-1:0]   variance_o;
  logic               warm_up_o;
  logic               saturated_o;
  logic               cfg_ready_o;

  int pending_results;
  int mismatch_count;
  int send_idle_pct   = 9;
  int recv_stall_pct  = 73;
  int requests_sent   = 0;
  int settings_loaded = 0;

  garch_variance_recursion_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sq_residual_i   (sq_residual_i),
    .init_variance_i (init_variance_i),
    .series_start_i  (series_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .variance_o      (variance_o),
    .warm_up_o       (warm_up_o),
    .saturated_o     (saturated_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  garch_variance_recursion_unit_checker checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .sq_residual_i   (sq_residual_i),
    .init_variance_i (init_variance_i),
    .series_start_i  (series_start_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .variance_i      (variance_o),
    .warm_up_i       (warm_up_o),
    .saturated_i     (saturated_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pending_o       (pending_results),
    .fail_count_o    (mismatch_count)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // The result side holds off at random, at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Extremes, values between minus one and one in Q16.16, or anything at all.
  function automatic logic [DataW-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      4, 5, 6: return DataW'($urandom_range(32'h0002_0000)) - 32'h0001_0000;
      default: return DataW'($urandom());
    endcase
  endfunction

  // Offers one request, after a random gap, and holds it until it is taken.
  task automatic send_request(input logic [DataW-1:0] e2,
                              input logic [DataW-1:0] h0,
                              input logic             start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    sq_residual_i   <= e2;
    init_variance_i <= h0;
    series_start_i  <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    requests_sent++;
  endtask

  // Stops sending and waits for every predicted variance to come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // One register write; the caller lowers valid after the last of a burst.
  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [DataW-1:0]   data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Loads a full set of registers once the block has gone idle.
  // The unused upper bits of the order words carry random data.
  task automatic apply_settings(input logic [DataW-1:0]  omega_w,
                                input logic [OrderW-1:0] p,
                                input logic [OrderW-1:0] q,
                                input logic [DataW-1:0]  a1,
                                input logic [DataW-1:0]  a2,
                                input logic [DataW-1:0]  g1,
                                input logic [DataW-1:0]  g2);
    drain_results();
    write_register(RegOmega, omega_w);
    write_register(RegArchOrder, (DataW'($urandom()) & ~DataW'(3)) | DataW'(p));
    write_register(RegGarchOrder, (DataW'($urandom()) & ~DataW'(3)) | DataW'(q));
    write_register(RegArchCoefOne, a1);
    write_register(RegArchCoefTwo, a2);
    write_register(RegGarchCoefOne, g1);
    write_register(RegGarchCoefTwo, g2);
    write_register(RegSpare, DataW'($urandom()));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    settings_loaded++;
  endtask

  // Random settings, then mostly ongoing series with the odd restart.
  // Halfway through, the sender waits for all results before going on.
  task automatic run_segment(input int count);
    int i;
    apply_settings(pick_word(), OrderW'($urandom_range(3)), OrderW'($urandom_range(3)),
                   pick_word(), pick_word(), pick_word(), pick_word());
    for (i = 0; i < count; i++) begin
      if (i == count / 2) begin
        drain_results();
      end
      send_request(pick_word(), pick_word(), ($urandom_range(11) == 0));
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct);
    int s;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (s = 0; s < 3; s++) begin
      run_segment(50);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings with no start flag: the first request is still warm-up.
    send_request(32'h7FFF_FFFF, 32'h0001_2345, 1'b0);
    send_request(32'h8000_0000, 32'h8000_0000, 1'b0);

    // Extreme weights, a zero warm-up slot, then a restart mid-series.
    apply_settings(32'h0001_0000, 2'd2, 2'd1, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0000, 32'h7FFF_FFFF);
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_request(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_request(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_request(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_request(32'h0000_8000, 32'h0004_0000, 1'b1);
    send_request(32'h0002_0000, 32'h0000_0000, 1'b0);
    send_request(32'h0001_8000, 32'h0000_0000, 1'b0);

    // Both orders zero: every value is the constant term.
    apply_settings(32'h8000_0000, 2'd0, 2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_request(32'h8000_0000, 32'h8000_0000, 1'b0);

    // Orders above the limit, driven into positive saturation.
    apply_settings(32'h7FFF_FFFF, 2'd3, 2'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);

    // ARCH only, driven into negative saturation.
    apply_settings(32'h8000_0000, 2'd1, 2'd0, 32'h7FFF_FFFF, 32'h0000_0000,
                   32'h0000_0000, 32'h0000_0000);
    send_request(32'h8000_0000, 32'h0000_0000, 1'b1);
    send_request(32'h8000_0000, 32'h0000_0000, 1'b0);

    // Orders raised mid-series: warm-up picks up at the current position.
    // A weight of one half on plus and minus one LSB checks rounding of halves.
    apply_settings(32'h0000_4000, 2'd2, 2'd2, 32'h0000_8000, 32'h0000_4000,
                   32'h0000_C000, 32'h0000_2000);
    send_request(32'h0000_0001, 32'h0003_0000, 1'b0);
    send_request(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    send_request(32'h0000_1000, 32'h0000_0000, 1'b0);

    // Two zero warm-up slots, then two initial-variance slots.
    apply_settings(32'h0000_0000, 2'd2, 2'd0, 32'h0000_8000, 32'hFFFF_8000,
                   32'h0001_0000, 32'h0001_0000);
    send_request(32'h0001_0000, 32'h7FFF_FFFF, 1'b1);
    send_request(32'h0003_0000, 32'h7FFF_FFFF, 1'b0);
    send_request(32'h0002_0000, 32'h7FFF_FFFF, 1'b0);
    apply_settings(32'h0001_0000, 2'd0, 2'd2, 32'h0001_0000, 32'h0001_0000,
                   32'h0000_8000, 32'hFFFF_C000);
    send_request(32'h0001_0000, 32'h0005_0000, 1'b1);
    send_request(32'h0001_0000, 32'h0006_0000, 1'b0);
    send_request(32'h0001_0000, 32'h0007_0000, 1'b0);

    // Random part under the three idling mixes.
    run_phase(9, 73);
    run_phase(73, 9);
    run_phase(0, 0);

    drain_results();
    repeat (8) @(posedge clk_i);

    $display("Ran %0d requests under %0d register settings and three idling mixes,",
             requests_sent, settings_loaded);
    $display("with restarts, order changes mid-series, warm-up and saturation both ways.");
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #400_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: garch_variance_recursion_unit.f
hdl/garch_pkg.sv
hdl/garch_cfg.sv
hdl/garch_core.sv
hdl/garch_variance_recursion_unit.sv
tb/garch_variance_recursion_unit_checker.sv
tb/garch_variance_recursion_unit_test.sv
